// ===== rtl/ccx_pkg.sv =====
package ccx_pkg;

    localparam int CW    = 16;
    localparam int RW    = CW - 1;
    localparam int DW    = CW + 1;
    localparam int OW    = CW + 2;
    localparam int D2W   = 2 * CW + 1;
    localparam int KW    = 2 * CW + 3;
    localparam int NW    = DW + KW;
    localparam int AW    = 2 * CW;
    localparam int PW    = 4 * CW - 2;
    localparam int SW    = PW / 2;
    localparam int QB    = CW + 5;
    localparam int REMW  = D2W + QB;
    localparam int LANES = 4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_COINC = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [D2W-1:0]       d2;
        logic signed [NW-1:0] nfx;
        logic signed [NW-1:0] nfy;
        logic                 miss;
        logic                 coinc;
    } ctx_t;

    typedef struct packed {
        logic [PW-1:0] n;
        logic [PW-1:0] res;
        logic [PW-1:0] bitv;
        ctx_t          ctx;
    } sq_word_t;

    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic [LANES-1:0]     neg;
        logic                 miss;
        logic                 coinc;
    } tail_t;

    typedef struct packed {
        logic [LANES-1:0][REMW-1:0] rem;
        logic [LANES-1:0][QB-1:0]   q;
        logic [REMW-1:0]            dsh;
        tail_t                      tail;
    } dv_word_t;

endpackage

// ===== rtl/ccx_sqrt_cell.sv =====
module ccx_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ccx_pkg::sq_word_t  in_word,
    output logic               out_valid,
    output ccx_pkg::sq_word_t  out_word
);

    logic              valid_reg;
    ccx_pkg::sq_word_t word_reg;
    ccx_pkg::sq_word_t word_next;
    logic [ccx_pkg::PW-1:0] trial;

    always_comb begin
        trial = in_word.res + in_word.bitv;
        word_next = in_word;
        word_next.bitv = in_word.bitv >> 2;
        if (in_word.n >= trial) begin
            word_next.n   = in_word.n - trial;
            word_next.res = (in_word.res >> 1) + in_word.bitv;
        end else begin
            word_next.res = in_word.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/ccx_div_cell.sv =====
module ccx_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ccx_pkg::dv_word_t  in_word,
    output logic               out_valid,
    output ccx_pkg::dv_word_t  out_word
);

    logic              valid_reg;
    ccx_pkg::dv_word_t word_reg;
    ccx_pkg::dv_word_t word_next;

    always_comb begin
        word_next = in_word;
        word_next.dsh = in_word.dsh >> 1;
        for (int l = 0; l < ccx_pkg::LANES; l++) begin
            if (in_word.rem[l] >= in_word.dsh) begin
                word_next.rem[l] = in_word.rem[l] - in_word.dsh;
                word_next.q[l]   = {in_word.q[l][ccx_pkg::QB-2:0], 1'b1};
            end else begin
                word_next.q[l]   = {in_word.q[l][ccx_pkg::QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/circle_circle_intersection.sv =====
// Circle pair intersection, fully pipelined: one word enters per cycle unless the pipe
// stalls, and each result passes five setup stages, one square-root cell per root bit,
// one multiply stage, one divider cell per quotient bit and one output stage. The pipe
// stalls only when a result is waiting at the output and the stage before it is full.
module circle_circle_intersection (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_first_center_x,
    input  logic signed [15:0]          s_first_center_y,
    input  logic [14:0]                 s_first_radius,
    input  logic signed [15:0]          s_second_center_x,
    input  logic signed [15:0]          s_second_center_y,
    input  logic [14:0]                 s_second_radius,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [17:0]          m_plus_point_x,
    output logic signed [17:0]          m_plus_point_y,
    output logic signed [17:0]          m_minus_point_x,
    output logic signed [17:0]          m_minus_point_y,
    output logic signed [17:0]          m_foot_x,
    output logic signed [17:0]          m_foot_y,
    output logic [1:0]                  m_status
);

    localparam int CW   = ccx_pkg::CW;
    localparam int RW   = ccx_pkg::RW;
    localparam int DW   = ccx_pkg::DW;
    localparam int OW   = ccx_pkg::OW;
    localparam int D2W  = ccx_pkg::D2W;
    localparam int KW   = ccx_pkg::KW;
    localparam int NW   = ccx_pkg::NW;
    localparam int AW   = ccx_pkg::AW;
    localparam int PW   = ccx_pkg::PW;
    localparam int SW   = ccx_pkg::SW;
    localparam int QB   = ccx_pkg::QB;
    localparam int REMW = ccx_pkg::REMW;
    localparam int PXW  = DW + SW + 1;
    localparam int VW   = QB + 3;

    logic en;
    logic out_free;

    // stage 1
    logic                 v1_reg;
    logic signed [CW-1:0] x0_1_reg, y0_1_reg;
    logic signed [DW-1:0] dx_1_reg, dy_1_reg;
    logic [RW-1:0]        r0_1_reg, r1_1_reg;
    logic [RW:0]          rs_1_reg;
    logic signed [RW:0]   rd_1_reg;
    // stage 2
    logic                 v2_reg;
    logic signed [CW-1:0] x0_2_reg, y0_2_reg;
    logic signed [DW-1:0] dx_2_reg, dy_2_reg;
    logic [AW-1:0]        dxx_2_reg, dyy_2_reg, sum2_2_reg;
    logic [2*RW-1:0]      r0q_2_reg, r1q_2_reg, dif2_2_reg;
    // stage 3
    logic                 v3_reg;
    logic signed [CW-1:0] x0_3_reg, y0_3_reg;
    logic signed [DW-1:0] dx_3_reg, dy_3_reg;
    logic [D2W-1:0]       d2_3_reg;
    logic signed [2*RW:0] rq_3_reg;
    logic [AW-1:0]        sum2_3_reg;
    logic [2*RW-1:0]      dif2_3_reg;
    // stage 4
    logic                 v4_reg;
    logic signed [CW-1:0] x0_4_reg, y0_4_reg;
    logic signed [DW-1:0] dx_4_reg, dy_4_reg;
    logic [D2W-1:0]       d2_4_reg;
    logic signed [KW-1:0] k_4_reg;
    logic [AW-1:0]        a_4_reg, b_4_reg;
    logic                 miss_4_reg, coinc_4_reg;
    // stage 5
    logic                 v5_reg;
    logic [PW-1:0]        p_5_reg;
    ccx_pkg::ctx_t        ctx_5_reg;
    // multiply stage
    logic                  v6_reg;
    logic signed [PXW-1:0] px_6_reg, py_6_reg;
    ccx_pkg::ctx_t         ctx_6_reg;

    logic signed [DW-1:0] dx_w, dy_w;
    logic signed [2*DW-1:0] dxx_w, dyy_w;
    logic signed [2*RW+1:0] dif2_w;
    logic [D2W-1:0]       sum2_ext, dif2_ext;
    logic signed [KW-1:0] k_w;
    logic [2*AW-1:0]      p_w;
    logic signed [DW+KW-1:0] nfx_w, nfy_w;
    logic [SW-1:0]         root_w;
    logic signed [PXW-1:0] px_w, py_w;

    logic                 sq_v [SW+1];
    ccx_pkg::sq_word_t    sq_w [SW+1];
    logic                 dv_v [QB+1];
    ccx_pkg::dv_word_t    dv_w [QB+1];

    assign out_free = !m_valid || m_ready;
    assign en       = out_free || !dv_v[QB];
    assign s_ready  = en;

    always_comb begin
        dx_w = {s_second_center_x[CW-1], s_second_center_x}
             - {s_first_center_x[CW-1], s_first_center_x};
        dy_w = {s_second_center_y[CW-1], s_second_center_y}
             - {s_first_center_y[CW-1], s_first_center_y};
        dxx_w  = dx_1_reg * dx_1_reg;
        dyy_w  = dy_1_reg * dy_1_reg;
        dif2_w = rd_1_reg * rd_1_reg;
        sum2_ext = {{(D2W-AW){1'b0}}, sum2_3_reg};
        dif2_ext = {{(D2W-2*RW){1'b0}}, dif2_3_reg};
        k_w = $signed({{(KW-D2W){1'b0}}, d2_3_reg})
            + {{(KW-2*RW-1){rq_3_reg[2*RW]}}, rq_3_reg};
        p_w   = a_4_reg * b_4_reg;
        nfx_w = dx_4_reg * k_4_reg;
        nfy_w = dy_4_reg * k_4_reg;
        root_w = sq_w[SW].res[SW-1:0];
        px_w = sq_w[SW].ctx.dx * $signed({1'b0, root_w});
        py_w = sq_w[SW].ctx.dy * $signed({1'b0, root_w});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= sq_v[SW];
        end
        if (en) begin
            x0_1_reg <= s_first_center_x;
            y0_1_reg <= s_first_center_y;
            dx_1_reg <= dx_w;
            dy_1_reg <= dy_w;
            r0_1_reg <= s_first_radius;
            r1_1_reg <= s_second_radius;
            rs_1_reg <= {1'b0, s_first_radius} + {1'b0, s_second_radius};
            rd_1_reg <= $signed({1'b0, s_first_radius}) - $signed({1'b0, s_second_radius});

            x0_2_reg   <= x0_1_reg;
            y0_2_reg   <= y0_1_reg;
            dx_2_reg   <= dx_1_reg;
            dy_2_reg   <= dy_1_reg;
            dxx_2_reg  <= dxx_w[AW-1:0];
            dyy_2_reg  <= dyy_w[AW-1:0];
            r0q_2_reg  <= r0_1_reg * r0_1_reg;
            r1q_2_reg  <= r1_1_reg * r1_1_reg;
            sum2_2_reg <= rs_1_reg * rs_1_reg;
            dif2_2_reg <= dif2_w[2*RW-1:0];

            x0_3_reg   <= x0_2_reg;
            y0_3_reg   <= y0_2_reg;
            dx_3_reg   <= dx_2_reg;
            dy_3_reg   <= dy_2_reg;
            d2_3_reg   <= {1'b0, dxx_2_reg} + {1'b0, dyy_2_reg};
            rq_3_reg   <= $signed({1'b0, r0q_2_reg}) - $signed({1'b0, r1q_2_reg});
            sum2_3_reg <= sum2_2_reg;
            dif2_3_reg <= dif2_2_reg;

            x0_4_reg    <= x0_3_reg;
            y0_4_reg    <= y0_3_reg;
            dx_4_reg    <= dx_3_reg;
            dy_4_reg    <= dy_3_reg;
            d2_4_reg    <= d2_3_reg;
            k_4_reg     <= k_w;
            a_4_reg     <= sum2_3_reg - d2_3_reg[AW-1:0];
            b_4_reg     <= d2_3_reg[AW-1:0] - {{(AW-2*RW){1'b0}}, dif2_3_reg};
            miss_4_reg  <= (d2_3_reg > sum2_ext) || (d2_3_reg < dif2_ext);
            coinc_4_reg <= (d2_3_reg == '0);

            p_5_reg         <= miss_4_reg ? '0 : p_w[PW-1:0];
            ctx_5_reg.x0    <= x0_4_reg;
            ctx_5_reg.y0    <= y0_4_reg;
            ctx_5_reg.dx    <= dx_4_reg;
            ctx_5_reg.dy    <= dy_4_reg;
            ctx_5_reg.d2    <= d2_4_reg;
            ctx_5_reg.nfx   <= nfx_w[NW-1:0];
            ctx_5_reg.nfy   <= nfy_w[NW-1:0];
            ctx_5_reg.miss  <= miss_4_reg;
            ctx_5_reg.coinc <= coinc_4_reg;

            px_6_reg  <= px_w;
            py_6_reg  <= py_w;
            ctx_6_reg <= sq_w[SW].ctx;
        end
    end

    // square root chain
    assign sq_v[0]      = v5_reg;
    assign sq_w[0].n    = p_5_reg;
    assign sq_w[0].res  = '0;
    assign sq_w[0].bitv = {2'b01, {(PW-2){1'b0}}};
    assign sq_w[0].ctx  = ctx_5_reg;

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        ccx_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_word   (sq_w[i]),
            .out_valid (sq_v[i+1]),
            .out_word  (sq_w[i+1])
        );
    end

    // rounding bias folded into the magnitude
    function automatic logic [REMW-1:0] biased_mag(input logic signed [NW-1:0] num,
                                                   input logic [D2W-1:0] d2);
        logic [NW-1:0] d2e;
        logic [NW-1:0] m;
        d2e = {{(NW-D2W){1'b0}}, d2};
        m = num[NW-1] ? (d2e - num) : (d2e + num);
        return {{(REMW-NW){1'b0}}, m};
    endfunction

    logic signed [NW-1:0] lane_num [ccx_pkg::LANES];

    always_comb begin
        lane_num[0] = ctx_6_reg.nfx;
        lane_num[1] = ctx_6_reg.nfy;
        lane_num[2] = {{(NW-PXW){px_6_reg[PXW-1]}}, px_6_reg};
        lane_num[3] = {{(NW-PXW){py_6_reg[PXW-1]}}, py_6_reg};
        dv_w[0].dsh        = {ctx_6_reg.d2, {QB{1'b0}}};
        dv_w[0].tail.x0    = ctx_6_reg.x0;
        dv_w[0].tail.y0    = ctx_6_reg.y0;
        dv_w[0].tail.miss  = ctx_6_reg.miss;
        dv_w[0].tail.coinc = ctx_6_reg.coinc;
        for (int l = 0; l < ccx_pkg::LANES; l++) begin
            dv_w[0].rem[l]      = biased_mag(lane_num[l], ctx_6_reg.d2);
            dv_w[0].q[l]        = '0;
            dv_w[0].tail.neg[l] = lane_num[l][NW-1];
        end
    end
    assign dv_v[0] = v6_reg;

    // divider chain
    for (genvar i = 0; i < QB; i++) begin : g_div
        ccx_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_word   (dv_w[i]),
            .out_valid (dv_v[i+1]),
            .out_word  (dv_w[i+1])
        );
    end

    function automatic logic [OW:0] sat_out(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] hi;
        logic signed [VW-1:0] lo;
        hi = $signed({{(VW-OW+1){1'b0}}, {(OW-1){1'b1}}});
        lo = $signed({{(VW-OW+1){1'b1}}, {(OW-1){1'b0}}});
        if (v > hi) begin
            return {1'b1, hi[OW-1:0]};
        end else if (v < lo) begin
            return {1'b1, lo[OW-1:0]};
        end
        return {1'b0, v[OW-1:0]};
    endfunction

    ccx_pkg::dv_word_t    fin;
    logic signed [QB:0]   sq [ccx_pkg::LANES];
    logic signed [VW-1:0] fx, fy, v0, v1, v2, v3;
    logic [OW:0]          s0, s1, s2, s3, s4, s5;
    logic                 clipped;

    always_comb begin
        fin = dv_w[QB];
        for (int l = 0; l < ccx_pkg::LANES; l++) begin
            sq[l] = fin.tail.neg[l] ? -$signed({1'b0, fin.q[l]}) : $signed({1'b0, fin.q[l]});
        end
        fx = {{(VW-CW){fin.tail.x0[CW-1]}}, fin.tail.x0} + {{(VW-QB-1){sq[0][QB]}}, sq[0]};
        fy = {{(VW-CW){fin.tail.y0[CW-1]}}, fin.tail.y0} + {{(VW-QB-1){sq[1][QB]}}, sq[1]};
        v0 = fx - {{(VW-QB-1){sq[3][QB]}}, sq[3]};
        v1 = fy + {{(VW-QB-1){sq[2][QB]}}, sq[2]};
        v2 = fx + {{(VW-QB-1){sq[3][QB]}}, sq[3]};
        v3 = fy - {{(VW-QB-1){sq[2][QB]}}, sq[2]};
        s0 = sat_out(v0);
        s1 = sat_out(v1);
        s2 = sat_out(v2);
        s3 = sat_out(v3);
        s4 = sat_out(fx);
        s5 = sat_out(fy);
        clipped = s0[OW] | s1[OW] | s2[OW] | s3[OW] | s4[OW] | s5[OW];
    end

    logic                 m_valid_reg;
    logic signed [OW-1:0] px_reg, py_reg, mx_reg, my_reg, fx_reg, fy_reg;
    logic [1:0]           status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= dv_v[QB];
        end
        if (out_free) begin
            if (fin.tail.coinc) begin
                px_reg     <= '0;
                py_reg     <= '0;
                mx_reg     <= '0;
                my_reg     <= '0;
                fx_reg     <= '0;
                fy_reg     <= '0;
                status_reg <= ccx_pkg::ST_COINC;
            end else if (fin.tail.miss) begin
                px_reg     <= '0;
                py_reg     <= '0;
                mx_reg     <= '0;
                my_reg     <= '0;
                fx_reg     <= s4[OW-1:0];
                fy_reg     <= s5[OW-1:0];
                status_reg <= ccx_pkg::ST_MISS;
            end else begin
                px_reg     <= s0[OW-1:0];
                py_reg     <= s1[OW-1:0];
                mx_reg     <= s2[OW-1:0];
                my_reg     <= s3[OW-1:0];
                fx_reg     <= s4[OW-1:0];
                fy_reg     <= s5[OW-1:0];
                status_reg <= clipped ? ccx_pkg::ST_SAT : ccx_pkg::ST_OK;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_plus_point_x  = px_reg;
    assign m_plus_point_y  = py_reg;
    assign m_minus_point_x = mx_reg;
    assign m_minus_point_y = my_reg;
    assign m_foot_x        = fx_reg;
    assign m_foot_y        = fy_reg;
    assign m_status        = status_reg;

    // coincident centers give all-zero point and foot fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ccx_pkg::ST_COINC |->
            m_foot_x == '0 && m_foot_y == '0 && m_plus_point_x == '0 && m_minus_point_y == '0)
        else $error("coincident word not cleared");

    // no intersection keeps the four point fields at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ccx_pkg::ST_MISS |->
            m_plus_point_x == '0 && m_plus_point_y == '0 &&
            m_minus_point_x == '0 && m_minus_point_y == '0)
        else $error("miss word carries points");

    // input stalls only behind a held result with a full last stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && dv_v[QB])
        else $error("input stalled without cause");

    // a held result stays put while the pipe stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(m_status) && $stable(m_foot_x))
        else $error("held result changed during stall");

endmodule
